// ===== rtl/tlqe_pkg.sv =====
package tlqe_pkg;

	// Defaults for the top-level parameters
	localparam int STATE_COUNT_DEFAULT = 4096;
	localparam int ACTIONS_DEFAULT = 4;
	localparam int RAM_DEPTH_DEFAULT = 16384;

	// Field widths
	localparam int RATE_W = 17;
	localparam int IDX_W = 12;
	localparam int ACT_W = 2;
	localparam int Q_W = 32;
	localparam int DRAW_W = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int IN_TDATA_W = 80;
	localparam int OUT_TDATA_W = 40;

	// Datapath widths: TD error, bit-serial product, rounded product
	localparam int MCAND_W = 36;
	localparam int ACC_W = MCAND_W + RATE_W + 1;
	localparam int RND_W = ACC_W - 16;
	localparam int MUL_CNT_W = $clog2(RATE_W);

	localparam logic [RATE_W-1:0] ONE_Q16 = 17'h1_0000;
	localparam logic [RATE_W-1:0] ALPHA_RESET = 17'd6554;
	localparam logic [RATE_W-1:0] GAMMA_RESET = 17'd58982;
	localparam logic [RATE_W-1:0] EPSILON_RESET = 17'd6554;

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);
	localparam logic signed [RND_W-1:0] Q_MAX = RND_W'(32'h7FFF_FFFF);
	localparam logic signed [RND_W-1:0] Q_MIN = -Q_MAX - RND_W'(1);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_LEARNING_RATE    = 2'd0,
		REG_DISCOUNT         = 2'd1,
		REG_EXPLORATION_RATE = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		FUNC_UPDATE = 1'b0,
		FUNC_CHOOSE = 1'b1
	} func_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_SCAN,
		ST_FETCH,
		ST_CUR,
		ST_MUL,
		ST_TD,
		ST_FIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [3:0]        pad;
		logic [ACT_W-1:0]  random_action;
		logic [DRAW_W-1:0] random_draw;
		logic [IDX_W-1:0]  next_state_index;
		logic signed [Q_W-1:0] reward;
		logic [ACT_W-1:0]  action_index;
		logic [IDX_W-1:0]  state_index;
	} in_item_t;

	typedef struct packed {
		logic [3:0]            pad;
		logic                  saturated;
		logic                  explored;
		logic signed [Q_W-1:0] q_value;
		logic [ACT_W-1:0]      chosen_action;
	} out_item_t;

endpackage

// ===== rtl/tabular_q_learning_engine.sv =====
// Tabular Q-learning engine, one item at a time through a bit-serial datapath.
// Per item: a 12-step row reduction, a row scan that reads one entry per cycle, then on an
// update two 17-step shift-add multiplies. The next item is taken only once the result
// has moved into the output register, so an output stall also holds back the input.
// Reset is asynchronous; a clearing pass then zeroes the table, taking no item.
module tabular_q_learning_engine #(
	parameter int STATE_COUNT = tlqe_pkg::STATE_COUNT_DEFAULT,
	parameter int ACTIONS = tlqe_pkg::ACTIONS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [tlqe_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [tlqe_pkg::RATE_W-1:0]       cfg_data,
	// input items
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// state_index[11:0], action_index[13:12], reward[45:14], next_state_index[57:46],
	// random_draw[73:58], random_action[75:74], zero[79:76]
	input  logic [tlqe_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// func[0]
	input  logic [0:0]                        s_axis_tuser,
	// result items
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// chosen_action[1:0], q_value[33:2], explored[34], saturated[35], zero[39:36]
	output logic [tlqe_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
	import tlqe_pkg::*;

	localparam int RW = $clog2(STATE_COUNT);
	localparam int AW = $clog2(ACTIONS);
	localparam int ADDR_W = RW + AW;
	localparam int DEPTH = STATE_COUNT * (2 ** AW);
	localparam int SCAN_W = AW + 1;
	localparam int MOD_CNT_W = $clog2(IDX_W);
	localparam logic [RW:0] SC_K = (RW + 1)'(STATE_COUNT);
	localparam logic [SCAN_W-1:0] ACT_K = SCAN_W'(ACTIONS);

	// Reduce a 2-bit action code modulo ACTIONS: the code is below 2*ACTIONS.
	function automatic logic [AW-1:0] act_mod(input logic [ACT_W-1:0] a);
		logic [4:0] t;
		t = 5'(a);
		if (t >= 5'(ACTIONS)) begin
			t = t - 5'(ACTIONS);
		end
		return t[AW-1:0];
	endfunction

	// One step of MSB-first restoring remainder by STATE_COUNT.
	function automatic logic [RW-1:0] row_step(input logic [RW-1:0] r, input logic b);
		logic [RW:0] t;
		t = {r, b};
		if (t >= SC_K) begin
			t = t - SC_K;
		end
		return t[RW-1:0];
	endfunction

	// ---------------------------------------------------------------- control state
	state_t state_q, state_nx;
	logic [RATE_W-1:0] alpha_q, gamma_q, eps_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [MOD_CNT_W-1:0] mod_cnt_q;
	logic [SCAN_W-1:0] scan_cnt_q;
	logic dv_q;
	logic [MUL_CNT_W-1:0] mul_cnt_q;
	logic pass_q;
	logic out_valid_q;

	// ---------------------------------------------------------------- item payload
	func_t func_q;
	logic [AW-1:0] act_q, ract_q, di_q, arg_q, col_q;
	logic explore_q;
	logic signed [Q_W-1:0] reward_q, best_q, cur_q;
	logic [IDX_W-1:0] s_sh_q, n_sh_q;
	logic [RW-1:0] srow_q, nrow_q;
	logic signed [MCAND_W-1:0] mcand_q;
	logic [RATE_W-1:0] mplier_q;
	logic signed [ACC_W-1:0] acc_q;
	out_item_t res_q, out_q;

	// ---------------------------------------------------------------- memory port
	logic ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [Q_W-1:0] ram_wdata, ram_rdata;

	// ---------------------------------------------------------------- datapath nets
	in_item_t in_item;
	logic accept, emit_load;
	logic [RATE_W-1:0] alpha_eff, gamma_eff;
	logic [RW-1:0] scan_row;
	logic [AW-1:0] col_sel;
	logic scan_take;
	logic signed [ACC_W-1:0] acc_next, acc_sum;
	logic signed [RND_W-1:0] rnd, nv;
	logic signed [MCAND_W-1:0] td;
	logic signed [Q_W-1:0] nv_clamped;
	logic nv_sat;

	assign in_item = in_item_t'(s_axis_tdata);
	assign accept = s_axis_tvalid && s_axis_tready;

	// Rates above one act as one.
	assign alpha_eff = (alpha_q > ONE_Q16) ? ONE_Q16 : alpha_q;
	assign gamma_eff = (gamma_q > ONE_Q16) ? ONE_Q16 : gamma_q;

	// Update scans the next state's row for its maximum; choose scans its own row.
	assign scan_row = (func_q == FUNC_UPDATE) ? nrow_q : srow_q;

	// Column of the single entry read after the scan.
	always_comb begin
		if (func_q == FUNC_UPDATE) begin
			col_sel = act_q;
		end else if (explore_q) begin
			col_sel = ract_q;
		end else begin
			col_sel = arg_q;
		end
	end

	// New maximum from the entry read back this cycle; strict compare keeps the lowest index.
	assign scan_take = dv_q && ((di_q == '0) || ($signed(ram_rdata) > best_q));

	// Shift-add multiply, multiplier bits MSB first.
	assign acc_next = (acc_q <<< 1) + (mplier_q[RATE_W-1] ? ACC_W'(mcand_q) : '0);

	// round(x / 65536), ties toward plus infinity.
	assign acc_sum = acc_q + ROUND_HALF;
	assign rnd = acc_sum[ACC_W-1:16];

	// TD error after the gamma pass; new value after the alpha pass.
	assign td = MCAND_W'(rnd) + MCAND_W'(reward_q) - MCAND_W'(cur_q);
	assign nv = rnd + RND_W'(cur_q);

	always_comb begin
		nv_sat = 1'b0;
		nv_clamped = nv[Q_W-1:0];
		if (nv > Q_MAX) begin
			nv_sat = 1'b1;
			nv_clamped = Q_MAX[Q_W-1:0];
		end else if (nv < Q_MIN) begin
			nv_sat = 1'b1;
			nv_clamped = Q_MIN[Q_W-1:0];
		end
	end

	// ---------------------------------------------------------------- next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_nx = ST_MOD;
				end
			end
			ST_MOD: begin
				if (mod_cnt_q == MOD_CNT_W'(IDX_W - 1)) begin
					state_nx = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_cnt_q == ACT_K) begin
					state_nx = ST_FETCH;
				end
			end
			ST_FETCH: state_nx = ST_CUR;
			ST_CUR: begin
				state_nx = (func_q == FUNC_UPDATE) ? ST_MUL : ST_EMIT;
			end
			ST_MUL: begin
				if (mul_cnt_q == MUL_CNT_W'(RATE_W - 1)) begin
					state_nx = pass_q ? ST_FIN : ST_TD;
				end
			end
			ST_TD: state_nx = ST_MUL;
			ST_FIN: state_nx = ST_EMIT;
			ST_EMIT: begin
				if (emit_load) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_CLEAR;
		endcase
	end

	// ---------------------------------------------------------------- outputs of the sequencer
	always_comb begin
		s_axis_tready = 1'b0;
		ram_we = 1'b0;
		ram_waddr = clr_addr_q;
		ram_wdata = '0;
		ram_raddr = {scan_row, scan_cnt_q[AW-1:0]};
		emit_load = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			ST_FETCH: begin
				ram_raddr = {srow_q, col_sel};
			end
			ST_FIN: begin
				ram_we = 1'b1;
				ram_waddr = {srow_q, col_q};
				ram_wdata = nv_clamped;
			end
			ST_EMIT: begin
				// a finished result moves out once the output register is free
				emit_load = !out_valid_q || m_axis_tready;
			end
			default: begin
			end
		endcase
	end

	// ---------------------------------------------------------------- control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			alpha_q <= ALPHA_RESET;
			gamma_q <= GAMMA_RESET;
			eps_q <= EPSILON_RESET;
			clr_addr_q <= '0;
			mod_cnt_q <= '0;
			scan_cnt_q <= '0;
			dv_q <= 1'b0;
			mul_cnt_q <= '0;
			pass_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;

			// configuration writes land at any time; unknown indexes are dropped
			if (cfg_we) begin
				case (cfg_index)
					REG_LEARNING_RATE: alpha_q <= cfg_data;
					REG_DISCOUNT: gamma_q <= cfg_data;
					REG_EXPLORATION_RATE: eps_q <= cfg_data;
					default: begin
					end
				endcase
			end

			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end

			if (accept) begin
				mod_cnt_q <= '0;
			end else if (state_q == ST_MOD) begin
				mod_cnt_q <= mod_cnt_q + MOD_CNT_W'(1);
			end

			// arm the row scan as the reduction finishes
			if (state_q == ST_MOD) begin
				scan_cnt_q <= '0;
				dv_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				dv_q <= (scan_cnt_q < ACT_K);
				if (scan_cnt_q < ACT_K) begin
					scan_cnt_q <= scan_cnt_q + SCAN_W'(1);
				end
			end

			if (state_q == ST_CUR) begin
				mul_cnt_q <= '0;
				pass_q <= 1'b0;
			end else if (state_q == ST_TD) begin
				mul_cnt_q <= '0;
				pass_q <= 1'b1;
			end else if (state_q == ST_MUL) begin
				mul_cnt_q <= mul_cnt_q + MUL_CNT_W'(1);
			end

			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func_t'(s_axis_tuser[0]);
			act_q <= act_mod(in_item.action_index);
			ract_q <= act_mod(in_item.random_action);
			reward_q <= in_item.reward;
			explore_q <= ({1'b0, in_item.random_draw} < eps_q);
			s_sh_q <= in_item.state_index;
			n_sh_q <= in_item.next_state_index;
			srow_q <= '0;
			nrow_q <= '0;
		end

		// fold one index bit a cycle into both row remainders
		if (state_q == ST_MOD) begin
			srow_q <= row_step(srow_q, s_sh_q[IDX_W-1]);
			nrow_q <= row_step(nrow_q, n_sh_q[IDX_W-1]);
			s_sh_q <= s_sh_q << 1;
			n_sh_q <= n_sh_q << 1;
		end

		if (state_q == ST_SCAN) begin
			di_q <= scan_cnt_q[AW-1:0];
			if (scan_take) begin
				best_q <= $signed(ram_rdata);
				arg_q <= di_q;
			end
		end

		if (state_q == ST_FETCH) begin
			col_q <= col_sel;
		end

		case (state_q)
			ST_CUR: begin
				// choose: result is the entry just read; update: start gamma * max
				cur_q <= $signed(ram_rdata);
				res_q <= '{pad: '0, saturated: 1'b0, explored: explore_q,
					q_value: $signed(ram_rdata), chosen_action: ACT_W'(col_q)};
				mcand_q <= MCAND_W'(best_q);
				mplier_q <= gamma_eff;
				acc_q <= '0;
			end
			ST_MUL: begin
				acc_q <= acc_next;
				mplier_q <= mplier_q << 1;
			end
			ST_TD: begin
				mcand_q <= td;
				mplier_q <= alpha_eff;
				acc_q <= '0;
			end
			ST_FIN: begin
				res_q <= '{pad: '0, saturated: nv_sat, explored: 1'b0,
					q_value: nv_clamped, chosen_action: ACT_W'(col_q)};
			end
			default: begin
			end
		endcase

		if (emit_load) begin
			out_q <= res_q;
		end
	end

	tlqe_ram #(
		.WIDTH(Q_W),
		.DEPTH(DEPTH)
	) u_qtab (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_q;

	// ---------------------------------------------------------------- assertions
	// an accepted item always starts with the row reduction
	a_accept_to_mod: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_MOD))
		else $error("accepted item did not enter row reduction");

	// the table is written only by the clearing pass or at the end of an update
	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ((state_q == ST_CLEAR) || (state_q == ST_FIN && func_q == FUNC_UPDATE)))
		else $error("table written outside clear or update finish");

	// no item is taken while the clearing pass runs
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !s_axis_tready)
		else $error("item accepted during clearing pass");

	// a result is never both an exploration and a clamped update
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(out_q.explored && out_q.saturated))
		else $error("explored and saturated both set");

endmodule

// ===== rtl/tlqe_ram.sv =====
module tlqe_ram #(
	parameter int WIDTH = tlqe_pkg::Q_W,
	parameter int DEPTH = tlqe_pkg::RAM_DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== bench/tabular_q_learning_engine_tb.sv =====
module tabular_q_learning_engine_tb;
	import tlqe_pkg::*;

	// Unused register index: a write there must leave every rate alone
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [Q_W-1:0] REWARD_MAX = 32'h7FFF_FFFF;
	localparam logic [Q_W-1:0] REWARD_MIN = 32'h8000_0000;
	localparam int ROW_W = ACTIONS_DEFAULT;
	localparam int RANDOM_PHASES = 6;
	localparam int STEPS_PER_PHASE = 213;
	// Clearing pass plus ~1300 items, gaps, stalls and one long hold,
	// taken several times over
	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AT_RESULT = 250;

	typedef struct {
		func_t    op;
		in_item_t data;
	} agent_step_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [RATE_W-1:0]      cfg_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [0:0]             s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	tabular_q_learning_engine u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Mirror of the Q table and the rate registers, updated in accept order
	bit signed [Q_W-1:0] value_table [RAM_DEPTH_DEFAULT];
	logic [RATE_W-1:0]   alpha_cfg = ALPHA_RESET;
	logic [RATE_W-1:0]   gamma_cfg = GAMMA_RESET;
	logic [RATE_W-1:0]   eps_cfg = EPSILON_RESET;

	agent_step_t pending_steps[$];
	out_item_t   expected_results[$];

	int  items_pushed = 0;
	int  results_done = 0;
	int  error_count = 0;
	int  cycle_count = 0;
	bit  in_fire = 1'b0;
	// Set for the closing phase: no idling on either side
	bit  steady = 1'b0;

	// round(x / 65536) with ties toward plus infinity
	function automatic longint scale_q16(longint x);
		return (x + 64'sd32768) >>> 16;
	endfunction

	// Work out the result of one accepted step and apply its write to the mirror
	function automatic out_item_t predict_outcome(agent_step_t st);
		out_item_t res;
		longint    best, cur, g, td, d, nv, rew, alpha, gamma;
		int        srow, nrow, slot, i;
		res = '0;
		srow = int'(st.data.state_index) * ROW_W;
		if (st.op == FUNC_UPDATE) begin
			nrow = int'(st.data.next_state_index) * ROW_W;
			slot = srow + int'(st.data.action_index);
			// take the row maximum before the write, which matters when both rows coincide
			best = value_table[nrow];
			for (i = 1; i < ROW_W; i++)
				if (value_table[nrow + i] > best)
					best = value_table[nrow + i];
			alpha = (alpha_cfg > ONE_Q16) ? longint'(ONE_Q16) : longint'(alpha_cfg);
			gamma = (gamma_cfg > ONE_Q16) ? longint'(ONE_Q16) : longint'(gamma_cfg);
			cur = value_table[slot];
			rew = st.data.reward;
			g = scale_q16(gamma * best);
			td = rew + g - cur;
			d = scale_q16(alpha * td);
			nv = cur + d;
			if (nv > longint'(REWARD_MAX)) begin
				nv = longint'(REWARD_MAX);
				res.saturated = 1'b1;
			end else if (nv < -64'sd2147483648) begin
				nv = -64'sd2147483648;
				res.saturated = 1'b1;
			end
			value_table[slot] = Q_W'(nv);
			res.chosen_action = st.data.action_index;
			res.q_value = Q_W'(nv);
		end else begin
			if (st.data.random_draw < eps_cfg) begin
				res.chosen_action = st.data.random_action;
				res.explored = 1'b1;
			end else begin
				// strict compare keeps the lowest index on ties
				res.chosen_action = '0;
				best = value_table[srow];
				for (i = 1; i < ROW_W; i++)
					if (value_table[srow + i] > best) begin
						best = value_table[srow + i];
						res.chosen_action = ACT_W'(i);
					end
			end
			res.q_value = value_table[srow + int'(res.chosen_action)];
		end
		return res;
	endfunction

	function automatic agent_step_t make_step(func_t op, logic [IDX_W-1:0] s,
			logic [ACT_W-1:0] a, logic [Q_W-1:0] r, logic [IDX_W-1:0] ns,
			logic [DRAW_W-1:0] draw, logic [ACT_W-1:0] ract);
		agent_step_t st;
		st.op = op;
		st.data = '0;
		st.data.state_index = s;
		st.data.action_index = a;
		st.data.reward = r;
		st.data.next_state_index = ns;
		st.data.random_draw = draw;
		st.data.random_action = ract;
		return st;
	endfunction

	// Mostly a small pool of states so values build up over time; the rest spans
	// the whole index range
	function automatic logic [IDX_W-1:0] pick_state();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return IDX_W'($urandom_range(0, 15));
		else if (r < 80)
			return (r < 75) ? '0 : '1;
		return IDX_W'($urandom);
	endfunction

	function automatic agent_step_t random_step();
		logic [Q_W-1:0]    r;
		logic [DRAW_W-1:0] draw;
		case ($urandom_range(0, 9))
			0: r = REWARD_MAX;
			1: r = REWARD_MIN;
			2, 3, 4: r = $urandom;
			default: r = Q_W'($urandom_range(0, 2 ** 21) - 2 ** 20);
		endcase
		case ($urandom_range(0, 9))
			0: draw = '0;
			1: draw = '1;
			// land right around the threshold
			2: draw = DRAW_W'(eps_cfg + $urandom_range(0, 2) - 1);
			default: draw = DRAW_W'($urandom);
		endcase
		return make_step($urandom_range(0, 1) ? FUNC_CHOOSE : FUNC_UPDATE, pick_state(),
			ACT_W'($urandom), r, pick_state(), draw, ACT_W'($urandom));
	endfunction

	function automatic logic [RATE_W-1:0] pick_rate();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return ONE_Q16;
			2: return '1;
			3: return RATE_W'($urandom);
			default: return RATE_W'($urandom_range(0, 65536));
		endcase
	endfunction

	task automatic queue_step(agent_step_t st);
		pending_steps.push_back(st);
		items_pushed++;
	endtask

	// One register write; the mirror follows since the block is idle here
	task automatic write_rate(logic [CFG_INDEX_W-1:0] idx, logic [RATE_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_LEARNING_RATE: alpha_cfg = val;
			REG_DISCOUNT: gamma_cfg = val;
			REG_EXPLORATION_RATE: eps_cfg = val;
			default: ;
		endcase
	endtask

	task automatic set_rates(logic [RATE_W-1:0] alpha, logic [RATE_W-1:0] gamma,
			logic [RATE_W-1:0] eps);
		write_rate(REG_LEARNING_RATE, alpha);
		write_rate(REG_DISCOUNT, gamma);
		write_rate(REG_EXPLORATION_RATE, eps);
	endtask

	// Hold until every queued step has produced its result
	task automatic drain();
		wait (results_done == items_pushed);
		repeat (4) @(negedge clk);
	endtask

	function automatic void check_field(string name, longint exp_v, longint got_v);
		if (exp_v != got_v) begin
			$display("%0t %s mismatch: expected %0d, actual %0d", $time, name, exp_v, got_v);
			error_count++;
		end
	endfunction

	// Input driver: advance to the next step once the current one is taken,
	// with random gaps between steps
	int send_gap = 0;
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || in_fire)) begin
			if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_steps.size() > 0) begin
				s_axis_tdata <= pending_steps[0].data;
				s_axis_tuser <= pending_steps[0].op;
				s_axis_tvalid <= 1'b1;
				void'(pending_steps.pop_front());
				if (!steady && $urandom_range(0, 5) == 0)
					send_gap = $urandom_range(1, 7);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver: random stall bursts, plus one long hold-off so the block backs
	// up and drops s_axis_tready while items keep being offered
	int  stall_left = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (!hold_done && results_done >= HOLD_AT_RESULT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (!steady && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 7) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Monitor: check results against the oldest expectation, then predict for
	// any step taken at this edge
	always @(posedge clk) begin
		out_item_t got, want;
		agent_step_t st;
		if (arst_n) begin
			in_fire <= s_axis_tvalid && s_axis_tready;
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				results_done <= results_done + 1;
				if (expected_results.size() == 0) begin
					$display("%0t result with none expected: expected nothing, actual %h",
						$time, m_axis_tdata);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("chosen_action", want.chosen_action, got.chosen_action);
					check_field("q_value", want.q_value, got.q_value);
					check_field("explored", want.explored, got.explored);
					check_field("saturated", want.saturated, got.saturated);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				st.op = func_t'(s_axis_tuser[0]);
				st.data = s_axis_tdata;
				expected_results.push_back(predict_outcome(st));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		logic [RATE_W-1:0] a, g, e;
		// Default rates: tie-breaking, explore threshold, same-state update
		queue_step(make_step(FUNC_CHOOSE, 0, 0, 0, 0, 16'hFFFF, 2));
		queue_step(make_step(FUNC_CHOOSE, 4095, 0, 0, 0, 0, 3));
		queue_step(make_step(FUNC_UPDATE, 5, 3, REWARD_MAX, 4095, 0, 0));
		queue_step(make_step(FUNC_UPDATE, 5, 1, REWARD_MIN, 5, 0, 0));
		queue_step(make_step(FUNC_UPDATE, 4095, 0, 1, 5, 0, 0));
		queue_step(make_step(FUNC_CHOOSE, 5, 0, 0, 0, 6554, 0));
		queue_step(make_step(FUNC_CHOOSE, 5, 0, 0, 0, 6553, 2));
		queue_step(make_step(FUNC_UPDATE, 4095, 3, '1, 4095, 16'hFFFF, 3));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		drain();

		// Full-strength rates, never explore: drive both clamps
		set_rates(ONE_Q16, ONE_Q16, '0);
		queue_step(make_step(FUNC_UPDATE, 7, 0, REWARD_MAX, 0, 0, 0));
		queue_step(make_step(FUNC_UPDATE, 8, 2, REWARD_MAX, 7, 0, 0));
		for (int i = 0; i < ROW_W; i++)
			queue_step(make_step(FUNC_UPDATE, 9, ACT_W'(i), REWARD_MIN, 10, 0, 0));
		queue_step(make_step(FUNC_UPDATE, 10, 1, REWARD_MIN, 9, 0, 0));
		queue_step(make_step(FUNC_UPDATE, 9, 2, 0, 9, 0, 0));
		queue_step(make_step(FUNC_CHOOSE, 9, 0, 0, 0, 0, 1));
		queue_step(make_step(FUNC_CHOOSE, 8, 0, 0, 0, 16'hFFFF, 1));
		drain();

		// Rates above one, always explore; the unused index must change nothing
		set_rates('1, '1, ONE_Q16);
		write_rate(REG_UNUSED, '0);
		queue_step(make_step(FUNC_CHOOSE, 8, 0, 0, 0, 16'hFFFF, 1));
		queue_step(make_step(FUNC_UPDATE, 11, 3, 12345, 8, 0, 0));
		drain();

		// Zero rates: an update leaves the entry as it is
		set_rates('0, '0, '1);
		queue_step(make_step(FUNC_UPDATE, 8, 2, REWARD_MAX, 8, 0, 0));
		queue_step(make_step(FUNC_CHOOSE, 0, 0, 0, 0, 16'hFFFF, 3));
		drain();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin a = ONE_Q16; g = ONE_Q16; e = 17'h0_8000; end
				1: begin a = '0; g = '0; e = '0; end
				2: begin a = '1; g = pick_rate(); e = ONE_Q16; end
				3: begin a = pick_rate(); g = pick_rate(); e = RATE_W'($urandom_range(0, 65536)); end
				4: begin a = 17'd1; g = 17'd65535; e = 17'd1; end
				default: begin a = pick_rate(); g = pick_rate(); e = pick_rate(); end
			endcase
			set_rates(a, g, e);
			if (phase == 3)
				write_rate(REG_UNUSED, RATE_W'($urandom));
			// closing phase runs with both sides always ready
			steady = (phase == RANDOM_PHASES - 1);
			for (int n = 0; n < STEPS_PER_PHASE; n++)
				queue_step(random_step());
			drain();
		end

		// let any stray result show up before the verdict
		repeat (80) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/tlqe_pkg.sv
rtl/tlqe_ram.sv
rtl/tabular_q_learning_engine.sv
bench/tabular_q_learning_engine_tb.sv
